// ===== hw/rtl/lap3d_pkg.sv =====
// Shared constants, types and helpers for the 3-D seven-point Laplacian block.
package lap3d_pkg;

    localparam int MAX_X     = 64;
    localparam int MAX_Z     = 64;
    localparam int SAMPLE_W  = 32;

    localparam int X_W       = $clog2(MAX_X);
    localparam int Z_W       = $clog2(MAX_Z);
    localparam int DEPTH     = MAX_X * MAX_Z;
    localparam int ADDR_W    = $clog2(DEPTH);

    localparam int SIZE_W    = 7;
    localparam int CNT_W     = 16;
    localparam int P_W       = CNT_W + 1;
    localparam int INV_W     = 32;
    localparam int VALUE_W   = 48;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Six neighbors minus six times the center needs four guard bits
    localparam int SUM_W     = SAMPLE_W + 4;
    localparam int LO_W      = SUM_W / 2;
    localparam int HI_W      = SUM_W - LO_W;
    localparam int PLO_W     = LO_W + INV_W;
    localparam int PHI_W     = HI_W + INV_W + 1;
    localparam int PROD_W    = SUM_W + INV_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_SIZE,
        CFG_Z_SIZE,
        CFG_PLANE_COUNT,
        CFG_LOWER_GHOST,
        CFG_UPPER_GHOST,
        CFG_INV_H_SQ
    } cfg_idx_t;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    // Per-transaction information handed from the sequencer to the datapath
    typedef struct packed {
        logic    emit;
        logic    zero;
        logic    last;
        logic    par;
        sample_t sample;
    } item_t;

    // Plane buffer access for one transaction
    typedef struct packed {
        logic  re;
        logic  we_a;
        logic  we_b;
        addr_t slot;
        addr_t dn;
        addr_t up;
        addr_t nxt;
    } mem_ctl_t;

    function automatic logic signed [SUM_W-1:0] sext_sum(input sample_t v);
        return {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

endpackage

// ===== hw/rtl/lap3d_ram.sv =====
// Generic one-write, two-read synchronous RAM with registered read data.
module lap3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    // Read returns the old contents when the same entry is written
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd0_reg <= mem[raddr0];
            rd1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ===== hw/rtl/lap3d_ctrl.sv =====
// Configuration registers, slab position tracking and plane buffer addressing.
module lap3d_ctrl import lap3d_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 acc,
    input  logic                 op,
    input  sample_t              sample,
    output logic                 fire,
    output item_t                item,
    output mem_ctl_t             mem_ctl,
    output logic [INV_W-1:0]     inv_h
);

    logic [SIZE_W-1:0] x_size_reg;
    logic [SIZE_W-1:0] z_size_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              lo_reg;
    logic              up_reg;
    logic [INV_W-1:0]  inv_reg;

    logic [X_W-1:0] x_reg, x_next;
    logic [Z_W-1:0] z_reg, z_next;
    logic [P_W-1:0] p_reg, p_next;

    logic [SIZE_W-1:0] nx, nz;
    logic [X_W-1:0]    x_end;
    logic [Z_W-1:0]    z_end;
    logic [CNT_W-1:0]  cnt;
    logic [P_W-1:0]    total, first_p, last_p;
    logic              drain, emit, zero, last, cfg_hit;

    // Clamp sizes to the supported range
    always_comb begin
        nx = x_size_reg;
        if (x_size_reg < SIZE_W'(3)) nx = SIZE_W'(3);
        else if (x_size_reg > SIZE_W'(MAX_X)) nx = SIZE_W'(MAX_X);
        nz = z_size_reg;
        if (z_size_reg < SIZE_W'(3)) nz = SIZE_W'(3);
        else if (z_size_reg > SIZE_W'(MAX_Z)) nz = SIZE_W'(MAX_Z);
        x_end   = X_W'(nx - SIZE_W'(1));
        z_end   = Z_W'(nz - SIZE_W'(1));
        cnt     = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        total   = P_W'(lo_reg) + P_W'(cnt) + P_W'(up_reg);
        first_p = P_W'(lo_reg) + P_W'(1);
        last_p  = P_W'(lo_reg) + P_W'(cnt);
    end

    // Classify the arriving transaction
    always_comb begin
        drain = p_reg >= total;
        emit  = (p_reg >= first_p) && (p_reg <= last_p);
        zero  = (x_reg == '0) || (x_reg == x_end) || (z_reg == '0) || (z_reg == z_end)
              || ((p_reg == first_p) && !lo_reg) || ((p_reg == last_p) && !up_reg);
        last  = emit && (p_reg == last_p) && (z_reg == z_end) && (x_reg == x_end);
        fire  = acc && (drain || !op);
    end

    // Advance the raster position
    always_comb begin
        x_next = x_reg;
        z_next = z_reg;
        p_next = p_reg;
        if (last) begin
            x_next = '0;
            z_next = '0;
            p_next = '0;
        end else if (x_reg == x_end) begin
            x_next = '0;
            if (z_reg == z_end) begin
                z_next = '0;
                p_next = p_reg + P_W'(1);
            end else begin
                z_next = z_reg + Z_W'(1);
            end
        end else begin
            x_next = x_reg + X_W'(1);
        end
    end

    always_comb begin
        case (cfg_idx_t'(cfg_addr))
            CFG_X_SIZE, CFG_Z_SIZE, CFG_PLANE_COUNT,
            CFG_LOWER_GHOST, CFG_UPPER_GHOST, CFG_INV_H_SQ: cfg_hit = cfg_wr_en;
            default: cfg_hit = 1'b0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_size_reg <= SIZE_W'(64);
            z_size_reg <= SIZE_W'(64);
            cnt_reg    <= CNT_W'(1);
            lo_reg     <= 1'b0;
            up_reg     <= 1'b0;
            inv_reg    <= INV_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_X_SIZE:      x_size_reg <= cfg_wr_data[SIZE_W-1:0];
                CFG_Z_SIZE:      z_size_reg <= cfg_wr_data[SIZE_W-1:0];
                CFG_PLANE_COUNT: cnt_reg    <= cfg_wr_data[CNT_W-1:0];
                CFG_LOWER_GHOST: lo_reg     <= cfg_wr_data[0];
                CFG_UPPER_GHOST: up_reg     <= cfg_wr_data[0];
                CFG_INV_H_SQ:    inv_reg    <= cfg_wr_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Position registers; a register write restarts the slab
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            x_reg <= '0;
            z_reg <= '0;
            p_reg <= '0;
        end else if (fire) begin
            x_reg <= x_next;
            z_reg <= z_next;
            p_reg <= p_next;
        end
    end

    // Buffer addresses: center row, rows above and below, next raster point
    always_comb begin
        addr_t row, nrow;
        row  = ADDR_W'(z_reg) * ADDR_W'(MAX_X);
        nrow = ADDR_W'(z_reg + Z_W'(1)) * ADDR_W'(MAX_X);
        mem_ctl.re   = fire;
        mem_ctl.we_a = fire && !drain && !p_reg[0];
        mem_ctl.we_b = fire && !drain && p_reg[0];
        mem_ctl.slot = row + ADDR_W'(x_reg);
        mem_ctl.dn   = ADDR_W'(z_reg - Z_W'(1)) * ADDR_W'(MAX_X) + ADDR_W'(x_reg);
        mem_ctl.up   = nrow + ADDR_W'(x_reg);
        mem_ctl.nxt  = (x_reg == x_end) ? nrow : row + ADDR_W'(x_reg + X_W'(1));
    end

    assign item.emit   = emit;
    assign item.zero   = zero;
    assign item.last   = last;
    assign item.par    = p_reg[0];
    assign item.sample = sample;
    assign inv_h       = inv_reg;

endmodule

// ===== hw/rtl/lap3d_arith.sv =====
// Stencil sum, split scaling multiply, rounding and saturation pipeline.
module lap3d_arith import lap3d_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               fire,
    input  item_t              item,
    input  logic [INV_W-1:0]   inv_h,
    input  sample_t            a0_rd0,
    input  sample_t            a0_rd1,
    input  sample_t            a1_rd0,
    input  sample_t            a1_rd1,
    input  sample_t            b0_rd0,
    input  sample_t            b0_rd1,
    input  sample_t            b1_rd0,
    input  sample_t            b1_rd1,
    output logic               out_valid,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_sat,
    output logic               out_last
);

    // Stage 1: registered item while buffer reads complete
    logic    v1_reg, zero1_reg, last1_reg, par1_reg;
    sample_t s1_reg;
    sample_t t0_reg, t1_reg;

    logic                     v2_reg, last2_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic                     v3_reg, last3_reg;
    logic [PLO_W-1:0]         plo_reg, plo_next;
    logic signed [PHI_W-1:0]  phi_reg, phi_next;

    logic                     v4_reg, sat4_reg, last4_reg;
    logic [VALUE_W-1:0]       val4_reg, val_next;
    logic                     sat_next;

    sample_t oth_dn, oth_up, oth_nxt, cur_lo;
    logic signed [PROD_W-1:0] prod, phe, ploe;

    localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(1) <<< (FRAC_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= fire && item.emit;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Shift the x taps from the previous look-ahead read
    always_ff @(posedge aclk) begin
        if (fire) begin
            t0_reg    <= t1_reg;
            t1_reg    <= par1_reg ? a1_rd0 : b1_rd0;
            par1_reg  <= item.par;
            zero1_reg <= item.zero;
            last1_reg <= item.last;
            s1_reg    <= item.sample;
        end
    end

    // Odd planes sit in buffer b, so the previous plane is in a
    always_comb begin
        oth_dn  = par1_reg ? a0_rd0 : b0_rd0;
        oth_up  = par1_reg ? a0_rd1 : b0_rd1;
        oth_nxt = par1_reg ? a1_rd0 : b1_rd0;
        cur_lo  = par1_reg ? b1_rd1 : a1_rd1;
    end

    always_comb begin
        logic signed [SUM_W-1:0] c;
        c = sext_sum(t1_reg);
        sum_next = sext_sum(oth_dn) + sext_sum(oth_up) + sext_sum(t0_reg)
                 + sext_sum(oth_nxt) + sext_sum(cur_lo) + sext_sum(s1_reg)
                 - ((c <<< 2) + (c <<< 1));
        if (zero1_reg) sum_next = '0;
    end

    // Split the scaling product into two narrow multiplies
    always_comb begin
        plo_next = PLO_W'(sum_reg[LO_W-1:0]) * PLO_W'(inv_h);
        phi_next = $signed(sum_reg[SUM_W-1:LO_W]) * $signed({1'b0, inv_h});
    end

    // Recombine, round half up and clip to the result width
    always_comb begin
        phe  = PROD_W'(phi_reg);
        ploe = $signed({{(PROD_W-PLO_W){1'b0}}, plo_reg});
        prod = (phe <<< LO_W) + ploe + ROUND_C;
        if ((prod[PROD_W-1:FRAC_W+VALUE_W-1] == '0)
            || (prod[PROD_W-1:FRAC_W+VALUE_W-1] == '1)) begin
            val_next = prod[FRAC_W+VALUE_W-1:FRAC_W];
            sat_next = 1'b0;
        end else begin
            val_next = prod[PROD_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                      : {1'b0, {(VALUE_W-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum_next;
            last2_reg <= last1_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            last3_reg <= last2_reg;
            val4_reg  <= val_next;
            sat4_reg  <= sat_next;
            last4_reg <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_value = val4_reg;
    assign out_sat   = sat4_reg;
    assign out_last  = last4_reg;

endmodule

// ===== hw/rtl/laplacian_7point_3d_stencil.sv =====
// Seven-point 3-D Laplacian over a streamed slab, two double-copied plane buffers.
// Throughput: one sample per cycle while the output is not stalled; a point is emitted when its upper neighbor arrives.
// An accepted sample passes the item, sum, product and result registers before m_tvalid rises.
// The pipeline stalls as a whole only while a result waits on the output register.
// Reset (aresetn low, synchronous) clears positions, valids and config registers to defaults;
// plane buffer contents are not cleared.
module laplacian_7point_3d_stencil import lap3d_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] sample
    input  logic                 s_tuser,   // [0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [47:0] value
    output logic                 m_tuser,   // [0] saturated
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    logic             en, acc, fire;
    item_t            item;
    mem_ctl_t         mem_ctl;
    logic [INV_W-1:0] inv_h;
    sample_t          a0_rd0, a0_rd1, a1_rd0, a1_rd1;
    sample_t          b0_rd0, b0_rd1, b1_rd0, b1_rd1;

    // Advance while the output register is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;

    lap3d_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .acc         (acc),
        .op          (s_tuser),
        .sample      (s_tdata),
        .fire        (fire),
        .item        (item),
        .mem_ctl     (mem_ctl),
        .inv_h       (inv_h)
    );

    // Buffer a, copy 0: rows below and above
    lap3d_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_a0 (
        .aclk (aclk), .we (mem_ctl.we_a), .waddr (mem_ctl.slot), .wdata (s_tdata),
        .re (mem_ctl.re), .raddr0 (mem_ctl.dn), .raddr1 (mem_ctl.up),
        .rdata0 (a0_rd0), .rdata1 (a0_rd1)
    );

    // Buffer a, copy 1: next raster point and same point
    lap3d_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_a1 (
        .aclk (aclk), .we (mem_ctl.we_a), .waddr (mem_ctl.slot), .wdata (s_tdata),
        .re (mem_ctl.re), .raddr0 (mem_ctl.nxt), .raddr1 (mem_ctl.slot),
        .rdata0 (a1_rd0), .rdata1 (a1_rd1)
    );

    lap3d_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_b0 (
        .aclk (aclk), .we (mem_ctl.we_b), .waddr (mem_ctl.slot), .wdata (s_tdata),
        .re (mem_ctl.re), .raddr0 (mem_ctl.dn), .raddr1 (mem_ctl.up),
        .rdata0 (b0_rd0), .rdata1 (b0_rd1)
    );

    lap3d_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_b1 (
        .aclk (aclk), .we (mem_ctl.we_b), .waddr (mem_ctl.slot), .wdata (s_tdata),
        .re (mem_ctl.re), .raddr0 (mem_ctl.nxt), .raddr1 (mem_ctl.slot),
        .rdata0 (b1_rd0), .rdata1 (b1_rd1)
    );

    lap3d_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .fire      (fire),
        .item      (item),
        .inv_h     (inv_h),
        .a0_rd0    (a0_rd0),
        .a0_rd1    (a0_rd1),
        .a1_rd0    (a1_rd0),
        .a1_rd1    (a1_rd1),
        .b0_rd0    (b0_rd0),
        .b0_rd1    (b0_rd1),
        .b1_rd0    (b1_rd0),
        .b1_rd1    (b1_rd1),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== hw/rtl/lap3d_checker.sv =====
// Port-level checks for the Laplacian stencil, bound to the top level.
module lap3d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // No result survives a reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // Clipped values sit at one of the two rails
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == 48'h8000_0000_0000)
        || (m_tdata == 48'h7FFF_FFFF_FFFF))
        else $error("saturated flag without rail value");

    // A blocked output holds off the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline stalled");

endmodule

bind laplacian_7point_3d_stencil lap3d_checker u_lap3d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
